// File: rtl/core/osccr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Color reply parser package
// Beat types, byte codes and default sizes shared by the parser modules.
// ----------------------------------------------------------------------------
package osccr_pkg;

  localparam int DEFAULT_PALETTE_ENTRIES = 16;
  localparam int DEFAULT_MAX_HEX_DIGITS  = 4;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_FOUR     = 8'h34;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_LOWER_R  = 8'h72;
  localparam logic [7:0] CH_LOWER_G  = 8'h67;
  localparam logic [7:0] CH_LOWER_B  = 8'h62;

  localparam logic KIND_BACKGROUND = 1'b0;
  localparam logic KIND_PALETTE    = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    logic       report_kind;
    logic [3:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_beat_t;

endpackage
`default_nettype wire

// File: rtl/core/osccr_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte beat until the parser stage consumes it.
// ----------------------------------------------------------------------------
module osccr_in_reg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  osccr_pkg::in_beat_t  in_beat,
  output logic                 stage_vld,
  output osccr_pkg::in_beat_t  stage_beat,
  input  wire                  stage_take
);

  logic                vld_r;
  logic                vld_nxt;
  osccr_pkg::in_beat_t beat_r;

  assign in_ready   = !vld_r || stage_take;
  assign stage_vld  = vld_r;
  assign stage_beat = beat_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (stage_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/osccr_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Component scaler
// Rounds a 1..4 digit hex value to eight bits: round(v*255/(16^digits-1)).
// ----------------------------------------------------------------------------
module osccr_scale (
  input  wire  [15:0] acc,
  input  wire  [2:0]  digits,
  output logic [7:0]  value
);

  logic [19:0] x3;
  logic [7:0]  q3_base;
  logic [12:0] r3;
  logic [7:0]  q3;
  logic [23:0] x4;
  logic [7:0]  q4_base;
  logic [16:0] r4;
  logic [7:0]  q4;

  // fold the span 2^n-1 as q = x>>n, remainder = low bits + q, one correction
  always_comb begin
    x3      = ({acc[11:0], 8'h00} - {8'h00, acc[11:0]}) + 20'd2047;
    q3_base = x3[19:12];
    r3      = {1'b0, x3[11:0]} + {5'h00, q3_base};
    q3      = q3_base + ((r3 >= 13'd4095) ? 8'd1 : 8'd0);

    x4      = ({acc, 8'h00} - {8'h00, acc}) + 24'd32767;
    q4_base = x4[23:16];
    r4      = {1'b0, x4[15:0]} + {9'h000, q4_base};
    q4      = q4_base + ((r4 >= 17'd65535) ? 8'd1 : 8'd0);
  end

  always_comb begin
    unique case (digits)
      3'd0, 3'd1: value = {acc[3:0], acc[3:0]};
      3'd2:       value = acc[7:0];
      3'd3:       value = q3;
      default:    value = q4;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/osccr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply parser stage
// Matches background and palette color reports byte by byte and registers
// each finished report for the result channel.
// ----------------------------------------------------------------------------
module osccr_parser #(
  parameter int PALETTE_ENTRIES = osccr_pkg::DEFAULT_PALETTE_ENTRIES,
  parameter int MAX_HEX_DIGITS  = osccr_pkg::DEFAULT_MAX_HEX_DIGITS
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   stage_vld,
  input  osccr_pkg::in_beat_t   stage_beat,
  output logic                  stage_take,
  output logic                  out_valid,
  input  wire                   out_ready,
  output osccr_pkg::out_beat_t  out_beat
);

  localparam int IDX_BITS = $clog2(PALETTE_ENTRIES + 1);
  localparam int IDX_W    = (IDX_BITS > 5) ? IDX_BITS : 5;
  localparam int MUL_W    = IDX_W + 4;
  localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(PALETTE_ENTRIES);
  localparam logic [MUL_W-1:0] MUL_SAT = MUL_W'(PALETTE_ENTRIES);
  localparam logic [2:0]       DIG_MAX = 3'(MAX_HEX_DIGITS);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ESC, PH_BR, PH_ONE, PH_ONEONE,
    PH_BG_R, PH_BG_G, PH_BG_B, PH_BG_COLON,
    PH_FOUR, PH_IDX0, PH_IDX1,
    PH_PAL_R, PH_PAL_G, PH_PAL_B, PH_PAL_COLON,
    PH_BG_DIG, PH_BG_SL, PH_PAL_DIG, PH_PAL_SL
  } phase_t;

  phase_t               phase_r, phase_nxt, phase_v, phase_restart;
  logic                 bgt_r, bgt_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic [2:0]           dcnt_r, dcnt_nxt;
  logic [15:0]          acc_r, acc_nxt;
  logic [7:0]           red_r, red_nxt;
  logic [7:0]           green_r, green_nxt;
  logic                 out_vld_r, out_vld_nxt;
  osccr_pkg::out_beat_t out_beat_r, out_beat_nxt;

  logic                 adv;
  logic                 emit;
  logic [7:0]           c;
  logic                 is_dec;
  logic                 is_hex;
  logic [3:0]           hval;
  logic [15:0]          acc_shift;
  logic [2:0]           dcnt_inc;
  logic [15:0]          sc_acc;
  logic [2:0]           sc_cnt;
  logic [7:0]           sc_val;
  logic [MUL_W-1:0]     idx_mul;
  logic [IDX_W-1:0]     idx_first;
  logic [IDX_W-1:0]     idx_more;

  assign adv        = stage_vld && (!out_vld_r || out_ready);
  assign stage_take = adv;
  assign out_valid  = out_vld_r;
  assign out_beat   = out_beat_r;

  assign c         = stage_beat.data_byte;
  assign is_dec    = (c >= 8'h30) && (c <= 8'h39);
  assign acc_shift = {acc_r[11:0], hval};
  assign dcnt_inc  = dcnt_r + 3'd1;
  assign sc_acc    = is_hex ? acc_shift : acc_r;
  assign sc_cnt    = is_hex ? dcnt_inc : dcnt_r;
  assign phase_v   = stage_beat.buffer_start ? PH_IDLE : phase_r;
  assign phase_restart = (c == osccr_pkg::CH_ESC) ? PH_ESC : PH_IDLE;

  always_comb begin
    is_hex = 1'b1;
    hval   = c[3:0];
    if (is_dec) begin
      hval = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      hval = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    idx_mul   = {{(MUL_W-IDX_W){1'b0}}, idx_r} * MUL_W'(10) + {{(MUL_W-4){1'b0}}, c[3:0]};
    idx_more  = (idx_mul > MUL_SAT) ? IDX_SAT : idx_mul[IDX_W-1:0];
    idx_first = ({{(MUL_W-4){1'b0}}, c[3:0]} > MUL_SAT) ? IDX_SAT
                                                       : {{(IDX_W-4){1'b0}}, c[3:0]};
  end

  osccr_scale u_scale (
    .acc    (sc_acc),
    .digits (sc_cnt),
    .value  (sc_val)
  );

  always_comb begin
    phase_nxt = phase_v;
    bgt_nxt   = stage_beat.buffer_start ? 1'b0 : bgt_r;
    idx_nxt   = idx_r;
    comp_nxt  = comp_r;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    emit      = 1'b0;

    unique case (phase_v)
      PH_ESC:    phase_nxt = (c == osccr_pkg::CH_RBRACKET) ? PH_BR : phase_restart;
      PH_BR: begin
        priority if ((c == osccr_pkg::CH_ONE) && !bgt_nxt) begin
          phase_nxt = PH_ONE;
        end else if (c == osccr_pkg::CH_FOUR) begin
          phase_nxt = PH_FOUR;
        end else begin
          phase_nxt = phase_restart;
        end
      end
      PH_ONE:    phase_nxt = (c == osccr_pkg::CH_ONE) ? PH_ONEONE : phase_restart;
      PH_ONEONE: phase_nxt = (c == osccr_pkg::CH_SEMI) ? PH_BG_R : phase_restart;
      PH_BG_R:   phase_nxt = (c == osccr_pkg::CH_LOWER_R) ? PH_BG_G : phase_restart;
      PH_BG_G:   phase_nxt = (c == osccr_pkg::CH_LOWER_G) ? PH_BG_B : phase_restart;
      PH_BG_B:   phase_nxt = (c == osccr_pkg::CH_LOWER_B) ? PH_BG_COLON : phase_restart;
      PH_BG_COLON: begin
        if (c == osccr_pkg::CH_COLON) begin
          bgt_nxt   = 1'b1;
          phase_nxt = PH_BG_DIG;
          comp_nxt  = 2'd0;
          dcnt_nxt  = 3'd0;
          acc_nxt   = 16'h0000;
        end else begin
          phase_nxt = phase_restart;
        end
      end
      PH_FOUR: begin
        if (c == osccr_pkg::CH_SEMI) begin
          idx_nxt   = '0;
          phase_nxt = PH_IDX0;
        end else begin
          phase_nxt = phase_restart;
        end
      end
      PH_IDX0: begin
        if (is_dec) begin
          idx_nxt   = idx_first;
          phase_nxt = PH_IDX1;
        end else begin
          phase_nxt = phase_restart;
        end
      end
      PH_IDX1: begin
        priority if (is_dec) begin
          idx_nxt = idx_more;
        end else if ((c == osccr_pkg::CH_SEMI) && (idx_r < IDX_SAT)) begin
          phase_nxt = PH_PAL_R;
        end else begin
          phase_nxt = phase_restart;
        end
      end
      PH_PAL_R:  phase_nxt = (c == osccr_pkg::CH_LOWER_R) ? PH_PAL_G : phase_restart;
      PH_PAL_G:  phase_nxt = (c == osccr_pkg::CH_LOWER_G) ? PH_PAL_B : phase_restart;
      PH_PAL_B:  phase_nxt = (c == osccr_pkg::CH_LOWER_B) ? PH_PAL_COLON : phase_restart;
      PH_PAL_COLON: begin
        if (c == osccr_pkg::CH_COLON) begin
          phase_nxt = PH_PAL_DIG;
          comp_nxt  = 2'd0;
          dcnt_nxt  = 3'd0;
          acc_nxt   = 16'h0000;
        end else begin
          phase_nxt = phase_restart;
        end
      end
      PH_BG_DIG, PH_PAL_DIG: begin
        if (is_hex) begin
          acc_nxt  = acc_shift;
          dcnt_nxt = dcnt_inc;
          if (dcnt_inc >= DIG_MAX) begin
            if (comp_r >= 2'd2) begin
              emit      = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              if (comp_r == 2'd0) begin
                red_nxt = sc_val;
              end else begin
                green_nxt = sc_val;
              end
              comp_nxt  = comp_r + 2'd1;
              dcnt_nxt  = 3'd0;
              acc_nxt   = 16'h0000;
              phase_nxt = (phase_v == PH_PAL_DIG) ? PH_PAL_SL : PH_BG_SL;
            end
          end
        end else begin
          priority if (dcnt_r == 3'd0) begin
            phase_nxt = phase_restart;
          end else if (comp_r >= 2'd2) begin
            emit      = 1'b1;
            phase_nxt = phase_restart;
          end else if (c == osccr_pkg::CH_SLASH) begin
            if (comp_r == 2'd0) begin
              red_nxt = sc_val;
            end else begin
              green_nxt = sc_val;
            end
            comp_nxt = comp_r + 2'd1;
            dcnt_nxt = 3'd0;
            acc_nxt  = 16'h0000;
          end else begin
            phase_nxt = phase_restart;
          end
        end
      end
      PH_BG_SL:  phase_nxt = (c == osccr_pkg::CH_SLASH) ? PH_BG_DIG : phase_restart;
      PH_PAL_SL: phase_nxt = (c == osccr_pkg::CH_SLASH) ? PH_PAL_DIG : phase_restart;
      default:   phase_nxt = phase_restart;
    endcase

    if (stage_beat.buffer_end) begin
      if (!emit && ((phase_nxt == PH_BG_DIG) || (phase_nxt == PH_PAL_DIG)) &&
          (dcnt_nxt != 3'd0) && (comp_nxt >= 2'd2)) begin
        emit = 1'b1;
      end
      phase_nxt = PH_IDLE;
    end
  end

  always_comb begin
    out_beat_nxt.report_kind   = (phase_v == PH_PAL_DIG) ? osccr_pkg::KIND_PALETTE
                                                         : osccr_pkg::KIND_BACKGROUND;
    out_beat_nxt.palette_index = (phase_v == PH_PAL_DIG) ? idx_r[3:0] : 4'h0;
    out_beat_nxt.red           = red_r;
    out_beat_nxt.green         = green_r;
    out_beat_nxt.blue          = sc_val;

    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = emit;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bgt_r     <= 1'b0;
      idx_r     <= '0;
      comp_r    <= 2'd0;
      dcnt_r    <= 3'd0;
      acc_r     <= 16'h0000;
      red_r     <= 8'h00;
      green_r   <= 8'h00;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        phase_r <= phase_nxt;
        bgt_r   <= bgt_nxt;
        idx_r   <= idx_nxt;
        comp_r  <= comp_nxt;
        dcnt_r  <= dcnt_nxt;
        acc_r   <= acc_nxt;
        red_r   <= red_nxt;
        green_r <= green_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r != 2'd3)
    else $error("component number out of range");

  a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DIG_MAX)
    else $error("digit count above limit");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_SAT)
    else $error("palette index above saturation");

  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |-> ((phase_v == PH_BG_DIG) || (phase_v == PH_PAL_DIG)))
    else $error("report emitted outside a component phase");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv && emit))
    else $error("result register loaded without a consumed beat");

endmodule
`default_nettype wire

// File: rtl/core/osc_color_reply_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Color reply parser
// A report passes the input register and then the result register to out_valid.
// Throughput: one byte per cycle while out_ready does not stall; the input register
// and the parser's result register are the only stages on the path.
// Reset: synchronous, active low; clears the match, the background-tried flag
// and both handshake stages.
// ----------------------------------------------------------------------------
module osc_color_reply_parser #(
  parameter int PALETTE_ENTRIES = osccr_pkg::DEFAULT_PALETTE_ENTRIES,
  parameter int MAX_HEX_DIGITS  = osccr_pkg::DEFAULT_MAX_HEX_DIGITS
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  osccr_pkg::in_beat_t   in_beat,
  output logic                  out_valid,
  input  wire                   out_ready,
  output osccr_pkg::out_beat_t  out_beat
);

  logic                stage_vld;
  logic                stage_take;
  osccr_pkg::in_beat_t stage_beat;

  osccr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .stage_vld  (stage_vld),
    .stage_beat (stage_beat),
    .stage_take (stage_take)
  );

  osccr_parser #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_HEX_DIGITS  (MAX_HEX_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_vld  (stage_vld),
    .stage_beat (stage_beat),
    .stage_take (stage_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color reply parser testbench
// Streams reply buffers through the byte channel: background and palette
// reports with random digits, indices and terminators, spoiled and noisy
// sequences, and odd buffer flags. Both channels idle in random bursts. Every
// report is checked field by field against an in-bench parser model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PALETTE_SIZE = osccr_pkg::DEFAULT_PALETTE_ENTRIES;
  localparam int MAX_DIGITS   = osccr_pkg::DEFAULT_MAX_HEX_DIGITS;
  localparam int TOTAL_BYTES  = 1950;
  localparam int QUIET_TAIL   = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] CH_DIGIT0    = "0";
  localparam logic [7:0] CH_DIGIT9    = "9";
  localparam logic [7:0] CH_LOWER_A   = "a";
  localparam logic [7:0] CH_LOWER_F   = "f";
  localparam logic [7:0] CH_UPPER_A   = "A";
  localparam logic [7:0] CH_UPPER_F   = "F";
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam int         NOT_HEX      = -1;

  typedef enum logic [4:0] {
    PS_IDLE, PS_ESC, PS_BRACKET, PS_ONE, PS_ONEONE,
    PS_BG_R, PS_BG_G, PS_BG_B, PS_BG_COLON,
    PS_FOUR, PS_IDX_FIRST, PS_IDX_MORE,
    PS_PAL_R, PS_PAL_G, PS_PAL_B, PS_PAL_COLON,
    PS_BG_DIGIT, PS_BG_SLASH, PS_PAL_DIGIT, PS_PAL_SLASH
  } parse_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  osccr_pkg::in_beat_t  in_beat = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  osccr_pkg::out_beat_t out_beat;

  parse_phase_t parse_phase = PS_IDLE;
  int           pal_index = 0;
  int           comp_num = 0;
  int           digit_num = 0;
  logic [15:0]  hex_acc = '0;
  logic [7:0]   red_kept = '0;
  logic [7:0]   green_kept = '0;
  bit           bg_tried = 1'b0;

  osccr_pkg::in_beat_t  pending_beats[$];
  osccr_pkg::out_beat_t reports_due[$];
  logic [7:0]           reply_buf[$];
  logic [7:0]           syntax_chars[10] = '{
    osccr_pkg::CH_ESC, osccr_pkg::CH_RBRACKET, osccr_pkg::CH_SEMI,
    osccr_pkg::CH_ONE, osccr_pkg::CH_FOUR, osccr_pkg::CH_SLASH,
    osccr_pkg::CH_COLON, osccr_pkg::CH_LOWER_R, osccr_pkg::CH_LOWER_G,
    osccr_pkg::CH_LOWER_B
  };

  int beats_issued = 0;
  int beats_taken = 0;
  int total_beats = TOTAL_BYTES;
  int send_gap = 0;
  int hold_left = 0;
  int errors = 0;

  osc_color_reply_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int hex_value(input logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return int'(c - CH_DIGIT0);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return NOT_HEX;
  endfunction

  function automatic logic [7:0] to_eight_bits(input logic [15:0] v, input int digits);
    int unsigned span;
    int d;
    d = (digits < 1) ? 1 : ((digits > 4) ? 4 : digits);
    span = (32'd1 << (4 * d)) - 1;
    return 8'((32'(v) * 255 + span / 2) / span);
  endfunction

  function automatic parse_phase_t after_miss(input logic [7:0] c);
    return (c == osccr_pkg::CH_ESC) ? PS_ESC : PS_IDLE;
  endfunction

  function automatic parse_phase_t step_if(input logic [7:0] c, input logic [7:0] want,
                                           input parse_phase_t next);
    return (c == want) ? next : after_miss(c);
  endfunction

  function automatic void start_components(input parse_phase_t next);
    parse_phase = next;
    comp_num = 0;
    digit_num = 0;
    hex_acc = '0;
  endfunction

  function automatic void keep_component();
    logic [7:0] v;
    v = to_eight_bits(hex_acc, digit_num);
    if (comp_num == 0) red_kept = v;
    else green_kept = v;
    comp_num = (comp_num + 1) & 3;
    digit_num = 0;
    hex_acc = '0;
  endfunction

  function automatic osccr_pkg::out_beat_t color_report();
    osccr_pkg::out_beat_t r;
    r.report_kind = (parse_phase == PS_PAL_DIGIT || parse_phase == PS_PAL_SLASH) ?
                    osccr_pkg::KIND_PALETTE : osccr_pkg::KIND_BACKGROUND;
    r.palette_index = (r.report_kind == osccr_pkg::KIND_PALETTE) ? 4'(pal_index) : 4'd0;
    r.red = red_kept;
    r.green = green_kept;
    r.blue = to_eight_bits(hex_acc, digit_num);
    return r;
  endfunction

  function automatic bit parse_reply_byte(input osccr_pkg::in_beat_t b,
                                          output osccr_pkg::out_beat_t rep);
    logic [7:0] c;
    int h;
    bit hit;
    c = b.data_byte;
    hit = 1'b0;
    rep = '0;
    if (b.buffer_start) begin
      bg_tried = 1'b0;
      parse_phase = PS_IDLE;
    end
    h = hex_value(c);
    case (parse_phase)
      PS_ESC:      parse_phase = step_if(c, osccr_pkg::CH_RBRACKET, PS_BRACKET);
      PS_BRACKET: begin
        if (c == osccr_pkg::CH_ONE && !bg_tried) parse_phase = PS_ONE;
        else if (c == osccr_pkg::CH_FOUR) parse_phase = PS_FOUR;
        else parse_phase = after_miss(c);
      end
      PS_ONE:      parse_phase = step_if(c, osccr_pkg::CH_ONE, PS_ONEONE);
      PS_ONEONE:   parse_phase = step_if(c, osccr_pkg::CH_SEMI, PS_BG_R);
      PS_BG_R:     parse_phase = step_if(c, osccr_pkg::CH_LOWER_R, PS_BG_G);
      PS_BG_G:     parse_phase = step_if(c, osccr_pkg::CH_LOWER_G, PS_BG_B);
      PS_BG_B:     parse_phase = step_if(c, osccr_pkg::CH_LOWER_B, PS_BG_COLON);
      PS_BG_COLON: begin
        if (c == osccr_pkg::CH_COLON) begin
          bg_tried = 1'b1;
          start_components(PS_BG_DIGIT);
        end else parse_phase = after_miss(c);
      end
      PS_FOUR: begin
        if (c == osccr_pkg::CH_SEMI) begin
          pal_index = 0;
          parse_phase = PS_IDX_FIRST;
        end else parse_phase = after_miss(c);
      end
      PS_IDX_FIRST: begin
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
          pal_index = int'(c - CH_DIGIT0);
          if (pal_index > PALETTE_SIZE) pal_index = PALETTE_SIZE;
          parse_phase = PS_IDX_MORE;
        end else parse_phase = after_miss(c);
      end
      PS_IDX_MORE: begin
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
          pal_index = pal_index * 10 + int'(c - CH_DIGIT0);
          if (pal_index > PALETTE_SIZE) pal_index = PALETTE_SIZE;
        end else if (c == osccr_pkg::CH_SEMI && pal_index < PALETTE_SIZE) begin
          parse_phase = PS_PAL_R;
        end else parse_phase = after_miss(c);
      end
      PS_PAL_R:    parse_phase = step_if(c, osccr_pkg::CH_LOWER_R, PS_PAL_G);
      PS_PAL_G:    parse_phase = step_if(c, osccr_pkg::CH_LOWER_G, PS_PAL_B);
      PS_PAL_B:    parse_phase = step_if(c, osccr_pkg::CH_LOWER_B, PS_PAL_COLON);
      PS_PAL_COLON: begin
        if (c == osccr_pkg::CH_COLON) start_components(PS_PAL_DIGIT);
        else parse_phase = after_miss(c);
      end
      PS_BG_DIGIT, PS_PAL_DIGIT: begin
        if (h != NOT_HEX) begin
          hex_acc = {hex_acc[11:0], 4'(h)};
          digit_num++;
          if (digit_num >= MAX_DIGITS) begin
            if (comp_num >= 2) begin
              rep = color_report();
              hit = 1'b1;
              parse_phase = PS_IDLE;
            end else begin
              keep_component();
              parse_phase = (parse_phase == PS_PAL_DIGIT) ? PS_PAL_SLASH : PS_BG_SLASH;
            end
          end
        end else if (digit_num == 0) parse_phase = after_miss(c);
        else if (comp_num >= 2) begin
          rep = color_report();
          hit = 1'b1;
          parse_phase = after_miss(c);
        end else if (c == osccr_pkg::CH_SLASH) keep_component();
        else parse_phase = after_miss(c);
      end
      PS_BG_SLASH:  parse_phase = step_if(c, osccr_pkg::CH_SLASH, PS_BG_DIGIT);
      PS_PAL_SLASH: parse_phase = step_if(c, osccr_pkg::CH_SLASH, PS_PAL_DIGIT);
      default:      parse_phase = after_miss(c);
    endcase
    if (b.buffer_end) begin
      if (!hit && (parse_phase == PS_BG_DIGIT || parse_phase == PS_PAL_DIGIT) &&
          digit_num > 0 && comp_num >= 2) begin
        rep = color_report();
        hit = 1'b1;
      end
      parse_phase = PS_IDLE;
    end
    return hit;
  endfunction

  function automatic logic [7:0] random_hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(CH_DIGIT0 + k);
    if (k < 16) return 8'(CH_LOWER_A + k - 10);
    return 8'(CH_UPPER_A + k - 16);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 2))
      0: return 8'($urandom);
      1: return syntax_chars[$urandom_range(0, 9)];
      default: return random_hex_char();
    endcase
  endfunction

  function automatic bit idle_allowed(input int n);
    return n < total_beats - QUIET_TAIL && (n % 256) < 192;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_buf.push_back(s[i]);
  endtask

  task automatic push_rgb_tag();
    reply_buf.push_back(osccr_pkg::CH_LOWER_R);
    reply_buf.push_back(osccr_pkg::CH_LOWER_G);
    reply_buf.push_back(osccr_pkg::CH_LOWER_B);
    reply_buf.push_back(osccr_pkg::CH_COLON);
  endtask

  task automatic flush_buffer(input bit random_flags);
    osccr_pkg::in_beat_t b;
    int last;
    int mid_start;
    int mid_end;
    bit lead;
    bit closing;
    last = reply_buf.size() - 1;
    lead = 1'b1;
    closing = 1'b1;
    mid_start = -1;
    mid_end = -1;
    if (random_flags) begin
      lead = $urandom_range(0, 9) != 0;
      closing = $urandom_range(0, 9) != 0;
      if ($urandom_range(0, 19) == 0) mid_start = $urandom_range(0, last);
      if ($urandom_range(0, 19) == 0) mid_end = $urandom_range(0, last);
    end
    foreach (reply_buf[i]) begin
      b.data_byte = reply_buf[i];
      b.buffer_start = (i == 0 && lead) || i == mid_start;
      b.buffer_end = (i == last && closing) || i == mid_end;
      pending_beats.push_back(b);
    end
    reply_buf.delete();
  endtask

  task automatic add_color_reply(input bit palette);
    int first;
    int pick;
    int pos;
    first = reply_buf.size();
    reply_buf.push_back(osccr_pkg::CH_ESC);
    reply_buf.push_back(osccr_pkg::CH_RBRACKET);
    if (palette) begin
      reply_buf.push_back(osccr_pkg::CH_FOUR);
      reply_buf.push_back(osccr_pkg::CH_SEMI);
      pick = $urandom_range(0, 19);
      if (pick < 14) push_text($sformatf("%0d", $urandom_range(0, PALETTE_SIZE - 1)));
      else if (pick < 16) push_text($sformatf("%03d", $urandom_range(0, PALETTE_SIZE + 2)));
      else if (pick < 19) push_text($sformatf("%0d", $urandom_range(PALETTE_SIZE, 99999)));
      reply_buf.push_back(osccr_pkg::CH_SEMI);
    end else begin
      reply_buf.push_back(osccr_pkg::CH_ONE);
      reply_buf.push_back(osccr_pkg::CH_ONE);
      reply_buf.push_back(osccr_pkg::CH_SEMI);
    end
    push_rgb_tag();
    for (int k = 0; k < 3; k++) begin
      repeat ($urandom_range(1, MAX_DIGITS)) reply_buf.push_back(random_hex_char());
      if (k < 2) reply_buf.push_back(osccr_pkg::CH_SLASH);
    end
    case ($urandom_range(0, 5))
      0: reply_buf.push_back(CH_BEL);
      1: begin
        reply_buf.push_back(osccr_pkg::CH_ESC);
        reply_buf.push_back(CH_BACKSLASH);
      end
      2: reply_buf.push_back(noise_byte());
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(first, reply_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: reply_buf[pos] = noise_byte();
        1: reply_buf.delete(pos);
        2: reply_buf.insert(pos, noise_byte());
        default: while (reply_buf.size() > pos) void'(reply_buf.pop_back());
      endcase
    end
  endtask

  task automatic add_random_buffer();
    int kind;
    if ($urandom_range(0, 29) == 0) begin
      reply_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 2)) reply_buf.push_back(noise_byte());
        kind = $urandom_range(0, 9);
        if (kind < 4) add_color_reply(1'b1);
        else if (kind < 8) add_color_reply(1'b0);
        else repeat ($urandom_range(1, 8)) reply_buf.push_back(noise_byte());
      end
      if (reply_buf.size() == 0) reply_buf.push_back(noise_byte());
    end
    flush_buffer(1'b1);
  endtask

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin : byte_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (beats_taken == beats_issued) begin
      if (send_gap > 0 || pending_beats.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        in_beat <= pending_beats.pop_front();
        in_valid <= 1'b1;
        beats_issued++;
        if (idle_allowed(beats_issued) && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 14);
      end
    end
  end

  always @(negedge clk) begin : report_sink
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rst_n && idle_allowed(beats_taken) && $urandom_range(0, 9) == 0)
        hold_left = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin : report_monitor
    osccr_pkg::out_beat_t rep;
    osccr_pkg::out_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (parse_reply_byte(in_beat, rep)) reports_due.push_back(rep);
        beats_taken++;
      end
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $time, out_beat);
          errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("report_kind", want.report_kind, out_beat.report_kind);
          check_field("palette_index", want.palette_index, out_beat.palette_index);
          check_field("red", want.red, out_beat.red);
          check_field("green", want.green, out_beat.green);
          check_field("blue", want.blue, out_beat.blue);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    reply_buf.push_back(osccr_pkg::CH_ESC);
    reply_buf.push_back(osccr_pkg::CH_RBRACKET);
    reply_buf.push_back(osccr_pkg::CH_FOUR);
    reply_buf.push_back(osccr_pkg::CH_SEMI);
    push_text("15");
    reply_buf.push_back(osccr_pkg::CH_SEMI);
    push_rgb_tag();
    push_text("ffff");
    reply_buf.push_back(osccr_pkg::CH_SLASH);
    push_text("0");
    reply_buf.push_back(osccr_pkg::CH_SLASH);
    push_text("A7");
    reply_buf.push_back(CH_BEL);
    flush_buffer(1'b0);
    reply_buf.push_back(8'hFF);
    flush_buffer(1'b0);
    reply_buf.push_back(8'h00);
    flush_buffer(1'b0);
    while (pending_beats.size() < TOTAL_BYTES) add_random_buffer();
    total_beats = pending_beats.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_taken < total_beats || reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
